>>> rtl/tse_pkg.sv
// tse_pkg: shared types and constants of the topological sort engine
// request and response payloads, command kinds, controller/datapath handshake
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

    localparam int NODE_W     = 5;
    // slots reachable through a 5-bit node field
    localparam int NODE_SLOTS = 32;

    typedef enum logic [1:0] {
        KIND_ADD_NODE = 2'd0,
        KIND_ADD_EDGE = 2'd1,
        KIND_SORT     = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_req;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              node_valid;
        logic              last;
        logic              has_cycle;
    } t_out_rsp;

    // controller -> datapath
    typedef struct packed {
        logic apply;   // execute add node / add edge / clear
        logic init;    // start of a sort run
        logic count;   // edge scan that builds in-degrees
        logic seed;    // slot scan that queues zero in-degree nodes
        logic pop;     // take the queue head
        logic dec;     // edge scan that lowers successor in-degrees
        logic emit;    // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic seed_last;
        logic queue_empty;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/tse_ctrl.sv
// tse_ctrl: sequencer of the topological sort engine
// steps a sort run through in-degree count, seeding, pop/scan and emit
// depends on tse_pkg
`timescale 1ns / 1ps
`default_nettype none

module tse_ctrl import tse_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_kind i_kind,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_COUNT = 7'b0000100,
        S_SEED  = 7'b0001000,
        S_POP   = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_kind == KIND_SORT) begin
                        n_state = S_INIT;
                    end else begin
                        o_cmd.apply = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_stat.seed_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                // empty here only when nothing was seeded
                if (i_stat.queue_empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.dec = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.queue_empty ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tse_dp.sv
// tse_dp: datapath of the topological sort engine
// node-present bits, edge list memory, in-degree scratch, ready queue, output register
// depends on tse_pkg
`timescale 1ns / 1ps
`default_nettype none

module tse_dp import tse_pkg::*; #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 128
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in_req i_req,
    input  wire t_cmd    i_cmd,
    output t_stat        o_stat,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_rsp     o_out_rsp
);

    localparam int SLOTS = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int AW    = $clog2(MAX_EDGES);
    localparam int EW    = $clog2(MAX_EDGES + 1);

    // graph
    logic [SLOTS-1:0]  r_present;
    logic [EW-1:0]     r_edge_cnt;
    logic [NODE_W-1:0] r_src_mem [MAX_EDGES];
    logic [NODE_W-1:0] r_dst_mem [MAX_EDGES];

    // edge scan
    logic [EW-1:0]     r_e;
    logic              r_rd_vld;
    logic [NODE_W-1:0] r_rd_src;
    logic [NODE_W-1:0] r_rd_dst;

    // sort run
    logic [EW-1:0]     r_indeg [SLOTS];
    logic [NODE_W-1:0] r_queue [SLOTS];
    logic [CW-1:0]     r_head;
    logic [CW-1:0]     r_tail;
    logic [CW-1:0]     r_emitted;
    logic [CW-1:0]     r_present_cnt;
    logic [SW-1:0]     r_slot;
    logic [NODE_W-1:0] r_cur;
    logic              r_have_cur;

    logic              r_out_valid;
    t_out_rsp          r_out_rsp;

    logic              a_ok;
    logic              b_ok;
    logic              add_node;
    logic              add_edge;
    logic              clear_all;
    logic              rd_issue;
    logic              scan_done;
    logic              queue_empty;
    logic [SW-1:0]     d_idx;
    logic [EW-1:0]     deg;
    logic              cnt_hit;
    logic              dec_hit;
    logic              push_dec;
    logic              seed_push;
    logic              push;
    logic [NODE_W-1:0] push_node;

    always_comb begin
        a_ok = ({1'b0, i_req.node_a} < (NODE_W + 1)'(SLOTS)) &&
               r_present[i_req.node_a[SW-1:0]];
        b_ok = ({1'b0, i_req.node_b} < (NODE_W + 1)'(SLOTS)) &&
               r_present[i_req.node_b[SW-1:0]];
        add_node  = i_cmd.apply && (i_req.kind == KIND_ADD_NODE) &&
                    ({1'b0, i_req.node_a} < (NODE_W + 1)'(SLOTS));
        add_edge  = i_cmd.apply && (i_req.kind == KIND_ADD_EDGE) && a_ok && b_ok &&
                    (r_edge_cnt < EW'(MAX_EDGES));
        clear_all = i_cmd.apply && (i_req.kind == KIND_CLEAR);

        rd_issue    = (i_cmd.count || i_cmd.dec) && (r_e != r_edge_cnt);
        scan_done   = (r_e == r_edge_cnt) && !r_rd_vld;
        queue_empty = (r_head == r_tail);

        // stored destinations are always present slots, so below SLOTS
        d_idx     = r_rd_dst[SW-1:0];
        deg       = r_indeg[d_idx];
        cnt_hit   = i_cmd.count && r_rd_vld;
        dec_hit   = i_cmd.dec && r_rd_vld && (r_rd_src == r_cur) && (deg != '0);
        push_dec  = dec_hit && (deg == EW'(1));
        seed_push = i_cmd.seed && r_present[r_slot] && (r_indeg[r_slot] == '0);
        push      = push_dec || seed_push;
        push_node = seed_push ? NODE_W'(r_slot) : r_rd_dst;

        o_stat.scan_done   = scan_done;
        o_stat.seed_last   = (r_slot == SW'(SLOTS - 1));
        o_stat.queue_empty = queue_empty;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_edge_cnt <= '0;
        end else if (clear_all) begin
            r_present  <= '0;
            r_edge_cnt <= '0;
        end else begin
            if (add_node) begin
                r_present[i_req.node_a[SW-1:0]] <= 1'b1;
            end
            if (add_edge) begin
                r_edge_cnt <= EW'(r_edge_cnt + 1'b1);
            end
        end
    end

    // edge list memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (add_edge) begin
            r_src_mem[r_edge_cnt[AW-1:0]] <= i_req.node_a;
            r_dst_mem[r_edge_cnt[AW-1:0]] <= i_req.node_b;
        end
        if (rd_issue) begin
            r_rd_src <= r_src_mem[r_e[AW-1:0]];
            r_rd_dst <= r_dst_mem[r_e[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_issue;
            if (i_cmd.init) begin
                r_e <= '0;
            end else if (rd_issue) begin
                r_e <= EW'(r_e + 1'b1);
            end else if ((i_cmd.count || i_cmd.dec) && scan_done) begin
                r_e <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_indeg[i] <= '0;
            end
        end else if (cnt_hit) begin
            r_indeg[d_idx] <= EW'(deg + 1'b1);
        end else if (dec_hit) begin
            r_indeg[d_idx] <= EW'(deg - 1'b1);
        end
        if (push) begin
            r_queue[r_tail[SW-1:0]] <= push_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_emitted     <= '0;
            r_present_cnt <= '0;
            r_slot        <= '0;
            r_have_cur    <= 1'b0;
        end else if (i_cmd.init) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_emitted     <= '0;
            r_present_cnt <= '0;
            r_slot        <= '0;
            r_have_cur    <= 1'b0;
        end else begin
            if (i_cmd.seed) begin
                r_slot <= SW'(r_slot + 1'b1);
                if (r_present[r_slot]) begin
                    r_present_cnt <= CW'(r_present_cnt + 1'b1);
                end
            end
            if (push) begin
                r_tail <= CW'(r_tail + 1'b1);
            end
            if (i_cmd.pop) begin
                r_head     <= CW'(r_head + 1'b1);
                r_have_cur <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_emitted <= CW'(r_emitted + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_cur <= r_queue[r_head[SW-1:0]];
        end
    end

    // output register; the node is sent after its scan so last is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_rsp.node_index <= r_have_cur ? r_cur : '0;
            r_out_rsp.node_valid <= r_have_cur;
            r_out_rsp.last       <= queue_empty;
            r_out_rsp.has_cycle  <= queue_empty &&
                (r_have_cur ? (CW'(r_emitted + 1'b1) < r_present_cnt)
                            : (r_present_cnt != '0));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

>>> rtl/topological_sort_engine_core.sv
// Topological sort engine (Kahn's algorithm) over a small directed graph.
// Input channel (i_in_valid / o_in_stall / i_in_req) takes one request:
// add node, add edge, run sort or clear graph. Output channel
// (o_out_valid / i_out_stall / o_out_rsp) returns the nodes of a sort in
// topological order, one response each; last marks the final one and
// has_cycle on it reports present nodes that were never emitted. An empty
// or fully cyclic graph gives one response with node_valid low.
// Add node, add edge and clear give no response and do not stall the input.
// A sort first builds in-degrees with a scan of the E stored edges and
// seeds the queue with a scan of the S = min(MAX_NODES, 32) slots, then
// pops each queued node and rescans the whole edge list through the
// single read port of the edge memory before emitting that node.
// Requests are not taken while a sort runs. A stalled response holds in
// the output register and the run waits for it.
// Reset (synchronous, active low) empties the graph and drops any run or
// pending response; edge memory contents need no clearing.
// Built from tse_ctrl (sequencer) and tse_dp (storage and arithmetic).
`timescale 1ns / 1ps
`default_nettype none

module topological_sort_engine_core import tse_pkg::*; #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 128
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_out_rsp     o_out_rsp
);

    t_cmd  cmd;
    t_stat stat;

    tse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_req.kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tse_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

>>> rtl/tse_checker.sv
// tse_checker: port-level checks of topological_sort_engine_core
// bound to the top level; depends on tse_pkg
`timescale 1ns / 1ps
`default_nettype none

module tse_checker import tse_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_in_req  i_in_req,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_out_rsp o_out_rsp
);

    // a stalled response stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed under stall");

    // a sort request blocks further requests while it runs
    a_sort_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.kind == KIND_SORT) |=> o_in_stall)
        else $error("request taken during sort");

    // graph edits leave the input unstalled and produce no response
    a_edit_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.kind != KIND_SORT) |=>
        !o_in_stall && !$rose(o_out_valid))
        else $error("graph edit stalled or produced a response");

    // an empty response closes the run; a cycle is only flagged at its end
    a_rsp_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.node_valid || o_out_rsp.last) &&
                        (!o_out_rsp.has_cycle || o_out_rsp.last))
        else $error("malformed response");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind topological_sort_engine_core tse_checker u_tse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

>>> dv/topological_sort_engine_core_tb.sv
// self-checking testbench for topological_sort_engine_core (kahn order with cycle flag)
// builds graphs through the request channel and checks every sorted node against a local model
// depends on tse_pkg and the rtl of topological_sort_engine_core
`timescale 1ns / 1ps

module topological_sort_engine_core_tb;
    import tse_pkg::*;

    localparam int GRAPH_NODES = 32;
    localparam int GRAPH_EDGES = 128;
    localparam int MAX_REPORTS = 10;

    class order_scoreboard;
        bit         present[NODE_SLOTS];
        logic [4:0] edge_from[GRAPH_EDGES];
        logic [4:0] edge_to[GRAPH_EDGES];
        int         n_edges;
        t_out_rsp   expected_order_q[$];
        int         n_checked;
        int         n_errors;
        int         n_sorts;
        int         n_cyclic;

        function new();
            foreach (present[i]) present[i] = 1'b0;
            n_edges   = 0;
            n_checked = 0;
            n_errors  = 0;
            n_sorts   = 0;
            n_cyclic  = 0;
        endfunction

        function bit slot_in_graph(logic [4:0] s);
            return (s < GRAPH_NODES) && present[s];
        endfunction

        function int pending();
            return expected_order_q.size();
        endfunction

        // kahn order: seed zero in-degree slots ascending, visit edges in insertion order
        function void predict_sort_order();
            int         indeg[NODE_SLOTS];
            logic [4:0] ready_q[$];
            logic [4:0] order_q[$];
            logic [4:0] cur;
            int         n_present;
            t_out_rsp   rsp;
            n_sorts++;
            n_present = 0;
            foreach (indeg[i]) begin
                indeg[i] = 0;
                if (slot_in_graph(5'(i))) n_present++;
            end
            for (int e = 0; e < n_edges; e++) indeg[edge_to[e]]++;
            for (int i = 0; i < NODE_SLOTS; i++) begin
                if (slot_in_graph(5'(i)) && indeg[i] == 0) ready_q = {ready_q, 5'(i)};
            end
            while (ready_q.size() > 0 && order_q.size() < GRAPH_NODES) begin
                cur = ready_q.pop_front();
                order_q = {order_q, cur};
                for (int e = 0; e < n_edges; e++) begin
                    if (edge_from[e] == cur && indeg[edge_to[e]] != 0) begin
                        indeg[edge_to[e]]--;
                        if (indeg[edge_to[e]] == 0) ready_q = {ready_q, edge_to[e]};
                    end
                end
            end
            if (order_q.size() == 0) begin
                rsp            = '0;
                rsp.last       = 1'b1;
                rsp.has_cycle  = (n_present != 0);
                if (rsp.has_cycle) n_cyclic++;
                expected_order_q = {expected_order_q, rsp};
                return;
            end
            foreach (order_q[k]) begin
                rsp            = '0;
                rsp.node_index = order_q[k];
                rsp.node_valid = 1'b1;
                if (k == order_q.size() - 1) begin
                    rsp.last      = 1'b1;
                    rsp.has_cycle = (order_q.size() < n_present);
                    if (rsp.has_cycle) n_cyclic++;
                end
                expected_order_q = {expected_order_q, rsp};
            end
        endfunction

        function void note_request(t_in_req r);
            case (r.kind)
                KIND_ADD_NODE: begin
                    if (r.node_a < GRAPH_NODES) present[r.node_a] = 1'b1;
                end
                KIND_ADD_EDGE: begin
                    if (slot_in_graph(r.node_a) && slot_in_graph(r.node_b)
                            && n_edges < GRAPH_EDGES) begin
                        edge_from[n_edges] = r.node_a;
                        edge_to[n_edges]   = r.node_b;
                        n_edges++;
                    end
                end
                KIND_SORT: predict_sort_order();
                default: begin
                    foreach (present[i]) present[i] = 1'b0;
                    n_edges = 0;
                end
            endcase
        endfunction

        function void check_response(t_out_rsp got);
            t_out_rsp want;
            n_checked++;
            if (expected_order_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected response idx=%0d valid=%0b last=%0b cyc=%0b",
                             $realtime, got.node_index, got.node_valid, got.last,
                             got.has_cycle);
                return;
            end
            want = expected_order_q.pop_front();
            if (got.node_index !== want.node_index || got.node_valid !== want.node_valid
                    || got.last !== want.last || got.has_cycle !== want.has_cycle) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"%0t: mismatch exp idx=%0d valid=%0b last=%0b cyc=%0b",
                              " got idx=%0d valid=%0b last=%0b cyc=%0b"},
                             $realtime, want.node_index, want.node_valid, want.last,
                             want.has_cycle, got.node_index, got.node_valid, got.last,
                             got.has_cycle);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_rsp o_out_rsp;

    order_scoreboard sb = new();

    int n_sent;
    bit tx_gaps_on;
    bit rx_gaps_on;
    bit tail_quiet;
    bit held_output;

    topological_sort_engine_core #(
        .MAX_NODES (GRAPH_NODES),
        .MAX_EDGES (GRAPH_EDGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [4:0] any_slot();
        return 5'($urandom_range(0, 31));
    endfunction

    // valid stays up between back-to-back requests; gaps drop it first
    task automatic send_request(input t_kind k, input logic [4:0] a, input logic [4:0] b);
        t_in_req r;
        r.kind   = k;
        r.node_a = a;
        r.node_b = b;
        if (!tail_quiet && tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
        n_sent++;
    endtask

    // mostly forward edges between added slots, some back edges and noise
    task automatic run_graph_case(input bit fresh);
        logic [4:0] slots[$];
        int         n_nodes;
        int         n_links;
        int         i;
        int         j;
        int         pick;
        if (fresh) send_request(KIND_CLEAR, any_slot(), any_slot());
        n_nodes = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
        for (int k = 0; k < n_nodes; k++) begin
            slots = {slots, any_slot()};
            send_request(KIND_ADD_NODE, slots[k], any_slot());
        end
        n_links = $urandom_range(0, n_nodes + 2);
        for (int k = 0; k < n_links; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_request(t_kind'($urandom_range(0, 3)), any_slot(), any_slot());
            end else if (pick < 3 || slots.size() < 2) begin
                send_request(KIND_ADD_EDGE, any_slot(), any_slot());
            end else begin
                i = $urandom_range(0, slots.size() - 2);
                j = $urandom_range(i + 1, slots.size() - 1);
                if (pick == 3)
                    send_request(KIND_ADD_EDGE, slots[j], slots[i]);
                else
                    send_request(KIND_ADD_EDGE, slots[i], slots[j]);
            end
        end
        send_request(KIND_SORT, any_slot(), any_slot());
    endtask

    initial begin : stimulus
        int         base;
        int         i;
        int         start;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        n_sent      = 0;
        tx_gaps_on  = 1'b0;
        rx_gaps_on  = 1'b0;
        tail_quiet  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty graph, duplicate add, edges to missing slots, self loop,
        // fully cyclic graph, duplicate edges, sort after clear
        send_request(KIND_SORT, 5'd31, 5'd31);
        send_request(KIND_ADD_NODE, 5'd0, 5'd31);
        send_request(KIND_ADD_NODE, 5'd31, 5'd0);
        send_request(KIND_ADD_NODE, 5'd0, 5'd0);
        send_request(KIND_ADD_EDGE, 5'd31, 5'd0);
        send_request(KIND_ADD_EDGE, 5'd0, 5'd7);
        send_request(KIND_ADD_EDGE, 5'd7, 5'd31);
        send_request(KIND_SORT, 5'd0, 5'd0);
        send_request(KIND_ADD_EDGE, 5'd0, 5'd0);
        send_request(KIND_SORT, 5'd0, 5'd0);
        send_request(KIND_CLEAR, 5'd31, 5'd31);
        send_request(KIND_ADD_NODE, 5'd3, 5'd0);
        send_request(KIND_ADD_NODE, 5'd4, 5'd0);
        send_request(KIND_ADD_EDGE, 5'd3, 5'd4);
        send_request(KIND_ADD_EDGE, 5'd4, 5'd3);
        send_request(KIND_SORT, 5'd0, 5'd0);
        send_request(KIND_CLEAR, 5'd0, 5'd0);
        send_request(KIND_ADD_NODE, 5'd1, 5'd0);
        send_request(KIND_ADD_NODE, 5'd2, 5'd0);
        send_request(KIND_ADD_EDGE, 5'd1, 5'd2);
        send_request(KIND_ADD_EDGE, 5'd1, 5'd2);
        send_request(KIND_ADD_NODE, 5'd9, 5'd0);
        send_request(KIND_SORT, 5'd0, 5'd0);
        send_request(KIND_CLEAR, 5'd0, 5'd0);
        send_request(KIND_SORT, 5'd0, 5'd0);

        // fill the edge list past its capacity, then sort the longest list
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_request(KIND_CLEAR, any_slot(), any_slot());
        base = $urandom_range(0, 24);
        for (int k = 0; k < 8; k++) send_request(KIND_ADD_NODE, 5'(base + k), any_slot());
        for (int k = 0; k < GRAPH_EDGES + 2; k++) begin
            i = $urandom_range(0, 6);
            send_request(KIND_ADD_EDGE, 5'(base + i), 5'(base + $urandom_range(i + 1, 7)));
        end
        send_request(KIND_SORT, any_slot(), any_slot());

        start = n_sent;
        while (n_sent - start < 30) begin
            tx_gaps_on = $urandom_range(0, 2) != 0;
            rx_gaps_on = $urandom_range(0, 2) != 0;
            if (n_sent - start > 15) tail_quiet = 1'b1;
            run_graph_case($urandom_range(0, 3) != 0);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("ran %0d requests and %0d sorts (%0d reported a cycle), %0d nodes returned",
                 n_sent, sb.n_sorts, sb.n_cyclic, sb.n_checked);
        $display("long output hold while requests queued: %0s, mismatches: %0d",
                 held_output ? "yes" : "no", sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("topological_sort_engine_core regression: pass");
        end else begin
            $display("topological_sort_engine_core regression: fail");
        end
        $finish;
    end

    // output side: random stall bursts plus one long hold mid-sort
    initial begin : receiver
        i_out_stall <= 1'b0;
        held_output  = 1'b0;
        wait (i_rst_n == 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held_output && sb.n_checked >= 10 && o_out_valid && !o_out_rsp.last) begin
                held_output = 1'b1;
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (!tail_quiet && rx_gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_rsp);
    end

    initial begin : watchdog
        #50_000_000;
        $display("topological_sort_engine_core regression: fail");
        $finish;
    end

endmodule
